// ===== sv/dlpg_pkg.sv =====
// Package for the debounced low-power gate: item layouts, codes and register indexes.
// No dependencies; used by the top level and by its checker.
package dlpg_pkg;

	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 48;
	localparam int REP_W       = 16;
	localparam int CFG_W       = 16;
	localparam int CFG_IDX_W   = 2;

	localparam logic [CFG_IDX_W-1:0] REG_ENTRY_THR = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EXIT_THR  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ENTRY_DEB = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_EXIT_DEB  = 2'd3;

	typedef enum logic [1:0] {
		TR_STAY_AWAKE = 2'd0,
		TR_ENTER      = 2'd1,
		TR_EXIT       = 2'd2,
		TR_STAY_LOW   = 2'd3
	} trans_t;

	typedef enum logic [2:0] {
		RSN_ENTRY_RESET     = 3'd0,
		RSN_ENTRY_PENDING   = 3'd1,
		RSN_ENTRY_SUSTAINED = 3'd2,
		RSN_WAKE            = 3'd3,
		RSN_EXIT_SUSTAINED  = 3'd4,
		RSN_EXIT_PENDING    = 3'd5,
		RSN_INHIBITED       = 3'd6
	} reason_t;

	// lowest bit last
	typedef struct packed {
		logic               transition_busy;
		logic               session_active;
		logic               wake_action;
		logic signed [15:0] activity_delta;
	} in_item_t;

	typedef struct packed {
		logic              suppress_failure;
		logic              inhibited;
		logic              resume_active;
		logic [REP_W-1:0]  exit_count;
		logic [REP_W-1:0]  entry_count;
		reason_t           reason;
		trans_t            transition_code;
		logic              mode_changed;
		logic              in_low_power;
	} out_item_t;

	localparam int IN_ITEM_W  = $bits(in_item_t);
	localparam int OUT_ITEM_W = $bits(out_item_t);

endpackage

// ===== sv/debounced_low_power_gate.sv =====
// Debounced low-power gate with hysteresis: top level.
// Depends on dlpg_pkg for item layouts and codes.
//
// Channel   Dir  Signals                       Contents (lowest bit first)
// s_*       in   s_tvalid s_tready s_tdata     activity_delta[15:0], wake_action,
//                                               session_active, transition_busy
// m_*       out  m_tvalid m_tready m_tdata     in_low_power, mode_changed, transition_code,
//                                               reason, entry_count, exit_count,
//                                               resume_active, inhibited, suppress_failure
// cfg_*     in   cfg_we cfg_index cfg_data     register write, no read-back
//
// One sample per cycle sustained while the output is not stalled; a taken sample enters the input register.
// The input register feeds the decision logic, which updates the gate state and the
// result register in the same cycle. A stalled output holds the result; the input
// register takes one more sample while the result register is full, then s_tready drops
// until the result leaves. arst_n clears the gate state, the config registers and both valid flags.
module debounced_low_power_gate
	import dlpg_pkg::*;
#(
	parameter int COUNT_WIDTH = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // activity_delta, wake_action, session_active, transition_busy
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // in_low_power, mode_changed, transition_code, reason,
	                                          // entry_count, exit_count, resume_active, inhibited,
	                                          // suppress_failure
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_W-1:0]       cfg_data
);

	localparam int CMP_W = (COUNT_WIDTH > REP_W) ? COUNT_WIDTH : REP_W;
	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
	localparam logic [CMP_W-1:0] REP_MAX = CMP_W'({REP_W{1'b1}});

	logic signed [15:0]     entry_thr_q;
	logic signed [15:0]     exit_thr_q;
	logic [15:0]            entry_deb_q;
	logic [15:0]            exit_deb_q;

	logic                   low_mode_q;
	logic                   latched_resume_q;
	logic [COUNT_WIDTH-1:0] entry_cnt_q;
	logic [COUNT_WIDTH-1:0] exit_cnt_q;

	in_item_t               item_s1;
	logic                   valid_s1;
	out_item_t              res_s2;
	logic                   valid_s2;

	logic                   advance;
	logic                   low_mode_d;
	logic                   latched_resume_d;
	logic [COUNT_WIDTH-1:0] entry_cnt_d;
	logic [COUNT_WIDTH-1:0] exit_cnt_d;
	out_item_t              res_d;

	function automatic logic [REP_W-1:0] report(input logic [COUNT_WIDTH-1:0] c);
		logic [CMP_W-1:0] ce;
		ce = CMP_W'(c);
		return (ce > REP_MAX) ? {REP_W{1'b1}} : ce[REP_W-1:0];
	endfunction

	function automatic logic [COUNT_WIDTH-1:0] bump(input logic [COUNT_WIDTH-1:0] c);
		return (c == CNT_MAX) ? CNT_MAX : c + 1'b1;
	endfunction

	function automatic logic reached(input logic [COUNT_WIDTH-1:0] c, input logic [15:0] d);
		return CMP_W'(c) >= CMP_W'(d);
	endfunction

	assign advance  = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = valid_s2;
	assign m_tdata  = OUT_TDATA_W'(res_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_thr_q <= '0;
			exit_thr_q  <= '0;
			entry_deb_q <= '0;
			exit_deb_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ENTRY_THR: entry_thr_q <= cfg_data;
				REG_EXIT_THR:  exit_thr_q  <= cfg_data;
				REG_ENTRY_DEB: entry_deb_q <= cfg_data;
				REG_EXIT_DEB:  exit_deb_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		logic [COUNT_WIDTH-1:0] cnt;
		low_mode_d       = low_mode_q;
		latched_resume_d = latched_resume_q;
		entry_cnt_d      = entry_cnt_q;
		exit_cnt_d       = exit_cnt_q;
		cnt              = '0;
		res_d            = '0;
		res_d.resume_active = item_s1.session_active;

		if (item_s1.transition_busy) begin
			low_mode_d       = 1'b0;
			latched_resume_d = 1'b0;
			entry_cnt_d      = '0;
			exit_cnt_d       = '0;
			res_d.mode_changed     = low_mode_q;
			res_d.transition_code  = low_mode_q ? TR_EXIT : TR_STAY_AWAKE;
			res_d.reason           = RSN_INHIBITED;
			res_d.inhibited        = 1'b1;
			res_d.suppress_failure = 1'b1;
		end else if (!low_mode_q) begin
			exit_cnt_d = '0;
			cnt = (item_s1.activity_delta < entry_thr_q) ? bump(entry_cnt_q) : '0;
			entry_cnt_d = cnt;
			if (reached(cnt, entry_deb_q)) begin
				low_mode_d       = 1'b1;
				latched_resume_d = item_s1.session_active;
				res_d.in_low_power     = 1'b1;
				res_d.mode_changed     = 1'b1;
				res_d.transition_code  = TR_ENTER;
				res_d.reason           = RSN_ENTRY_SUSTAINED;
				res_d.suppress_failure = 1'b1;
			end else begin
				res_d.transition_code = TR_STAY_AWAKE;
				res_d.reason = (cnt == '0) ? RSN_ENTRY_RESET : RSN_ENTRY_PENDING;
			end
			res_d.entry_count = report(cnt);
		end else begin
			entry_cnt_d = '0;
			if (item_s1.wake_action) begin
				low_mode_d = 1'b0;
				exit_cnt_d = '0;
				res_d.mode_changed     = 1'b1;
				res_d.transition_code  = TR_EXIT;
				res_d.reason           = RSN_WAKE;
				res_d.suppress_failure = 1'b1;
			end else begin
				cnt = (item_s1.activity_delta > exit_thr_q) ? bump(exit_cnt_q) : '0;
				if (reached(cnt, exit_deb_q)) begin
					low_mode_d = 1'b0;
					exit_cnt_d = '0;
					res_d.mode_changed     = 1'b1;
					res_d.transition_code  = TR_EXIT;
					res_d.reason           = RSN_EXIT_SUSTAINED;
					res_d.suppress_failure = 1'b1;
				end else begin
					exit_cnt_d = cnt;
					res_d.in_low_power     = 1'b1;
					res_d.transition_code  = TR_STAY_LOW;
					res_d.reason           = RSN_EXIT_PENDING;
					res_d.exit_count       = report(cnt);
					res_d.resume_active    = latched_resume_q;
					res_d.suppress_failure = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1         <= 1'b0;
			valid_s2         <= 1'b0;
			low_mode_q       <= 1'b0;
			latched_resume_q <= 1'b0;
			entry_cnt_q      <= '0;
			exit_cnt_q       <= '0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
			if (advance && valid_s1) begin
				low_mode_q       <= low_mode_d;
				latched_resume_q <= latched_resume_d;
				entry_cnt_q      <= entry_cnt_d;
				exit_cnt_q       <= exit_cnt_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1 <= in_item_t'(s_tdata[IN_ITEM_W-1:0]);
		end
		if (advance && valid_s1) begin
			res_s2 <= res_d;
		end
	end

endmodule

// ===== sv/dlpg_checker.sv =====
// Port-level checker for the debounced low-power gate, bound to the top level.
// Depends on dlpg_pkg for the result layout.
module dlpg_checker
	import dlpg_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tready,
	input  logic                   m_tvalid,
	input  logic                   m_tready,
	input  logic [OUT_TDATA_W-1:0] m_tdata
);

	out_item_t res;
	logic      last_lp_q;
	logic      last_resume_q;
	logic      delivered;

	assign res       = out_item_t'(m_tdata[OUT_ITEM_W-1:0]);
	assign delivered = m_tvalid && m_tready;

	// track the mode and resume state shown by the last delivered transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_lp_q     <= 1'b0;
			last_resume_q <= 1'b0;
		end else if (delivered) begin
			last_lp_q     <= res.in_low_power;
			last_resume_q <= res.resume_active;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result dropped or changed while stalled");

	a_change: assert property (@(posedge clk) disable iff (!arst_n)
		delivered |-> res.mode_changed == (res.in_low_power != last_lp_q))
		else $error("mode_changed disagrees with mode sequence");

	a_resume: assert property (@(posedge clk) disable iff (!arst_n)
		delivered && res.in_low_power && !res.mode_changed |-> res.resume_active == last_resume_q)
		else $error("resume state altered while staying low");

	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled with output free");

endmodule

bind debounced_low_power_gate dlpg_checker u_dlpg_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
